// File: sv/a2i_pkg.sv
// Shared types, character codes and helpers for the ASCII to int64 parser.
package a2i_pkg;

   localparam int VALUE_BITS      = 64;
   localparam int BASE_BITS       = 6;
   localparam int DIGIT_BITS      = 7;
   localparam int END_OFFSET_BITS = 16;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 6;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUMBER_BASE   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BINARY_PREFIX = 1'd1;

   // bases
   localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_BIN  = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;

   // character codes
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_B   = 8'h42;
   localparam logic [7:0] CH_UP_X   = 8'h58;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_B   = 8'h62;
   localparam logic [7:0] CH_LO_X   = 8'h78;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;
   localparam logic [7:0] UP_BIAS   = 8'h37;   // 'A' - 10
   localparam logic [7:0] LO_BIAS   = 8'h57;   // 'a' - 10

   localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 7'd64;

   localparam logic [VALUE_BITS-1:0] INT64_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] INT64_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   typedef enum logic [4:0] {
      PH_DONE   = 5'b00001,
      PH_SPACE  = 5'b00010,
      PH_PREFIX = 5'b00100,
      PH_ZERO   = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       string_start;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0]  value;
      logic                          range_error;
      logic                          converted;
      logic [END_OFFSET_BITS-1:0]    end_offset;
   } rsp_word_type;

   // digit or letter value, DIGIT_NONE for any other byte
   function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [7:0] ch);
      logic [7:0] d;
      d = 8'(DIGIT_NONE);
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         d = ch - CH_ZERO;
      end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
         d = ch - LO_BIAS;
      end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
         d = ch - UP_BIAS;
      end
      return d[DIGIT_BITS-1:0];
   endfunction

   function automatic logic is_space(input logic [7:0] ch);
      return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   endfunction

endpackage

// File: sv/a2i_req_if.sv
// Request channel: one byte of the string per word.
interface a2i_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       string_start;

   modport source (output valid, output char_code, output string_start, input ready);
   modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

// File: sv/a2i_rsp_if.sv
// Response channel: one converted number per word.
interface a2i_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic               range_error;
   logic               converted;
   logic [15:0]        end_offset;

   modport source (output valid, output value, output range_error, output converted,
                   output end_offset, input ready);
   modport sink   (input valid, input value, input range_error, input converted,
                   input end_offset, output ready);
endinterface

// File: sv/a2i_mac.sv
// Multiply-subtract of the negative accumulator with exact range check.
module a2i_mac (
   input  logic signed [a2i_pkg::VALUE_BITS-1:0] acc,
   input  logic [a2i_pkg::BASE_BITS-1:0]         base,
   input  logic [a2i_pkg::BASE_BITS-1:0]         digit,
   output logic signed [a2i_pkg::VALUE_BITS-1:0] acc_next,
   output logic                                  overflow
);
   import a2i_pkg::*;

   localparam int PROD_BITS = VALUE_BITS + BASE_BITS + 1;
   localparam int DIFF_BITS = PROD_BITS + 1;

   logic signed [PROD_BITS-1:0] prod;
   logic signed [DIFF_BITS-1:0] diff;

   // acc*base - c < INT64_MIN is the same test as (INT64_MIN + c) / base > acc
   assign prod     = acc * $signed({1'b0, base});
   assign diff     = {prod[PROD_BITS-1], prod} - $signed({{(DIFF_BITS-BASE_BITS){1'b0}}, digit});
   assign overflow = diff[DIFF_BITS-1] && (diff[DIFF_BITS-1:VALUE_BITS-1] != '1);
   assign acc_next = diff[VALUE_BITS-1:0];

endmodule

// File: sv/a2i_parse.sv
// Parse state and per-byte step: whitespace, sign, prefix and digit handling.
module a2i_parse #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  a2i_pkg::req_word_type           word,
   input  logic [a2i_pkg::BASE_BITS-1:0]   number_base,
   input  logic                            binary_prefix_enable,
   output logic                            emit,
   output a2i_pkg::rsp_word_type           result
);
   import a2i_pkg::*;

   phase_type                     phase_ff, phase_in;
   logic                          neg_ff, neg_in;
   logic [BASE_BITS-1:0]          base_ff, base_in;
   logic signed [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic                          ovf_ff, ovf_in;
   logic                          any_ff, any_in;
   logic [OFFSET_BITS-1:0]        off_ff, off_in;

   // state after the non-digit part of the step
   phase_type                     pre_phase;
   logic                          pre_stop;
   logic                          pre_neg;
   logic [BASE_BITS-1:0]          pre_base;
   logic signed [VALUE_BITS-1:0]  pre_acc;
   logic                          pre_ovf;
   logic                          pre_any;
   logic [OFFSET_BITS-1:0]        pre_off;

   logic [DIGIT_BITS-1:0]         digit;
   logic signed [VALUE_BITS-1:0]  mac_acc;
   logic                          mac_ovf;
   logic [END_OFFSET_BITS-1:0]    off_sat;
   logic                          range_err;

   function automatic logic [OFFSET_BITS-1:0] bump(input logic [OFFSET_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   always_comb begin
      logic [7:0] ch;
      ch        = word.char_code;
      pre_phase = phase_ff;
      pre_neg   = neg_ff;
      pre_base  = base_ff;
      pre_acc   = acc_ff;
      pre_ovf   = ovf_ff;
      pre_any   = any_ff;
      pre_off   = off_ff;
      if (word.string_start) begin
         pre_neg   = 1'b0;
         pre_base  = BASE_DEC;
         pre_acc   = '0;
         pre_ovf   = 1'b0;
         pre_any   = 1'b0;
         pre_off   = '0;
         pre_phase = PH_SPACE;
      end
      pre_stop = (pre_phase == PH_DONE);

      if (!pre_stop && pre_phase == PH_SPACE) begin
         if (is_space(ch)) begin
            pre_off  = bump(pre_off);
            pre_stop = 1'b1;
         end else begin
            pre_phase = PH_PREFIX;
            if (ch == CH_MINUS || ch == CH_PLUS) begin
               pre_neg  = (ch == CH_MINUS);
               pre_off  = bump(pre_off);
               pre_stop = 1'b1;
            end
         end
      end

      // base register is sampled here, once per string
      if (!pre_stop && pre_phase == PH_PREFIX) begin
         pre_base  = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
         pre_phase = PH_DIGITS;
         if (ch == CH_ZERO && (number_base == BASE_AUTO || number_base == BASE_HEX ||
             (number_base == BASE_BIN && binary_prefix_enable))) begin
            pre_any   = 1'b1;
            pre_acc   = '0;
            pre_base  = (number_base == BASE_AUTO) ? BASE_OCT : number_base;
            pre_phase = PH_ZERO;
            pre_off   = bump(pre_off);
            pre_stop  = 1'b1;
         end
      end

      // character after a leading zero may be a prefix letter
      if (!pre_stop && pre_phase == PH_ZERO) begin
         pre_phase = PH_DIGITS;
         if ((ch == CH_LO_X || ch == CH_UP_X) &&
             (pre_base == BASE_OCT || pre_base == BASE_HEX)) begin
            pre_base = BASE_HEX;
            pre_any  = 1'b0;
            pre_off  = bump(pre_off);
            pre_stop = 1'b1;
         end else if ((ch == CH_LO_B || ch == CH_UP_B) && binary_prefix_enable &&
                      (pre_base == BASE_OCT || pre_base == BASE_BIN)) begin
            pre_base = BASE_BIN;
            pre_any  = 1'b0;
            pre_off  = bump(pre_off);
            pre_stop = 1'b1;
         end
      end
   end

   assign digit = digit_value(word.char_code);

   a2i_mac u_mac (
      .acc      (pre_acc),
      .base     (pre_base),
      .digit    (digit[BASE_BITS-1:0]),
      .acc_next (mac_acc),
      .overflow (mac_ovf)
   );

   always_comb begin
      phase_in = pre_phase;
      neg_in   = pre_neg;
      base_in  = pre_base;
      acc_in   = pre_acc;
      ovf_in   = pre_ovf;
      any_in   = pre_any;
      off_in   = pre_off;
      emit     = 1'b0;
      if (!pre_stop) begin
         if (digit >= {1'b0, pre_base}) begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end else begin
            if (!pre_ovf) begin
               if (mac_ovf) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = mac_acc;
               end
            end
            any_in = 1'b1;
            off_in = bump(pre_off);
         end
      end
   end

   generate
      if (OFFSET_BITS > END_OFFSET_BITS) begin : g_off_wide
         assign off_sat = (|pre_off[OFFSET_BITS-1:END_OFFSET_BITS]) ? '1 :
                          pre_off[END_OFFSET_BITS-1:0];
      end else begin : g_off_narrow
         assign off_sat = END_OFFSET_BITS'(pre_off);
      end
   endgenerate

   // most negative accumulator with a plus sign is out of range too
   assign range_err = pre_ovf || (!pre_neg && pre_acc == $signed(INT64_MIN));

   always_comb begin
      if (range_err) begin
         result.value = pre_neg ? $signed(INT64_MIN) : $signed(INT64_MAX);
      end else if (pre_neg) begin
         result.value = pre_acc;
      end else begin
         result.value = -pre_acc;
      end
      result.range_error = range_err;
      result.converted   = pre_any;
      result.end_offset  = pre_any ? off_sat : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         neg_ff   <= 1'b0;
         base_ff  <= BASE_DEC;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         any_ff   <= 1'b0;
         off_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         any_ff   <= any_in;
         off_ff   <= off_in;
      end
   end

`ifndef ASSERT_OFF
   a_done_after_emit: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> phase_ff == PH_DONE)
      else $error("parser not done after result");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      emit && !result.converted |->
         result.value == '0 && result.end_offset == '0 && !result.range_error)
      else $error("unconverted result not zero");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      emit && result.range_error |->
         result.value == $signed(INT64_MIN) || result.value == $signed(INT64_MAX))
      else $error("range error without saturated value");
`endif

endmodule

// File: sv/ascii_to_int64_parser.sv
// Top level of the streaming ASCII to signed 64-bit integer parser.
//
//  channel   dir  handshake        payload
//  req_chan  in   valid / ready    char_code[7:0], string_start
//  rsp_chan  out  valid / ready    value[63:0], range_error, converted, end_offset[15:0]
//  csr_*     in   csr_we           csr_index[0], csr_wdata[5:0]
//
// One byte is taken per cycle unless a stalled rsp_chan holds one back;
// a word waits in the input register, and a result appears on rsp_chan
// the cycle after its terminating byte leaves that register. The rate is
// set by the 64x6 multiply-subtract and range check on the accumulator feedback path.
// Synchronous reset puts the parser in the done state (bytes ignored until a
// string start), base 0 (auto) and binary prefix enabled.
// A stalled rsp_chan only holds back a byte that would produce a second
// result, and the bytes queued behind it; other bytes keep flowing.
module ascii_to_int64_parser #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   a2i_req_if.sink                             req_chan,
   a2i_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [a2i_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [a2i_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import a2i_pkg::*;

   // configuration registers
   logic [BASE_BITS-1:0] number_base_ff;
   logic                 bin_prefix_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   req_word_type         in_word_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff;

   logic                 req_fire;
   logic                 rsp_free;
   logic                 advance;
   logic                 emit;
   rsp_word_type         result;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_AUTO;
         bin_prefix_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUMBER_BASE:   number_base_ff <= csr_wdata[BASE_BITS-1:0];
            CSR_BINARY_PREFIX: bin_prefix_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // a word leaves the input register unless it ends a number and the
   // result register cannot take it this cycle
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (!emit || rsp_free);

   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff.char_code    <= req_chan.char_code;
         in_word_ff.string_start <= req_chan.string_start;
      end
      if (advance && emit) begin
         rsp_word_ff <= result;
      end
   end

   a2i_parse #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parse (
      .clock                (clock),
      .reset                (reset),
      .advance              (advance),
      .word                 (in_word_ff),
      .number_base          (number_base_ff),
      .binary_prefix_enable (bin_prefix_ff),
      .emit                 (emit),
      .result               (result)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.value       = rsp_word_ff.value;
   assign rsp_chan.range_error = rsp_word_ff.range_error;
   assign rsp_chan.converted   = rsp_word_ff.converted;
   assign rsp_chan.end_offset  = rsp_word_ff.end_offset;

`ifndef ASSERT_OFF
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("input word dropped while blocked");

   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && rsp_valid_ff && emit)
      else $error("request stalled without a blocked result");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && emit))
      else $error("result appeared without a terminating byte");
`endif

endmodule
